// ===== src/wspbe_pkg.sv =====
// Shared constants for the WS2812 pixel bit encoder.
package wspbe_pkg;

  localparam int unsigned ColorW     = 8;
  localparam int unsigned ProdW      = 2 * ColorW;
  localparam int unsigned WordW      = 3 * ColorW;
  localparam int unsigned TickW      = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned SymCntW    = 5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ZERO_HIGH  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ONE_HIGH   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_PERIOD     = 2'd3;

  // Reset values of the configuration registers
  localparam logic [ColorW-1:0] BRIGHTNESS_RST = 8'd255;
  localparam logic [TickW-1:0]  ZERO_HIGH_RST  = 8'h14;
  localparam logic [TickW-1:0]  ONE_HIGH_RST   = 8'h28;
  localparam logic [TickW-1:0]  PERIOD_RST     = 8'h3C;

  // Index of the final symbol of a pixel
  localparam logic [SymCntW-1:0] LAST_SYM = 5'd23;

  // Floor of x / 255 for any x up to 255 * 255 (a product of two 8-bit values)
  function automatic logic [ColorW-1:0] div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] t;
    t = {1'b0, x} + {{(ColorW+1){1'b0}}, x[ProdW-1:ColorW]} + {{ProdW{1'b0}}, 1'b1};
    return t[ProdW-1:ColorW];
  endfunction

endpackage

// ===== src/ws2812_pixel_bit_encoder.sv =====
// WS2812 pixel bit encoder: scales a pixel and emits its 24 bit symbols.
//
// Input channel (in_valid/in_ready): one pixel per transfer, red, green and
// blue bytes plus a last-pixel flag. Each color is scaled by the brightness
// register as floor(c * brightness / 255).
// Output channel (out_valid/out_ready): 24 symbol transfers per pixel, green,
// red, blue, MSB first. Each carries the bit value, its high time and the low
// time (period minus high, floored at zero), plus pixel and frame end marks.
// Configuration: cfg_we with cfg_index and cfg_wdata writes a register;
// write only while the block is idle.
// Pipeline: multiply stage, divide-by-255 stage, symbol shifter, output
// register; a pixel passes through each in turn. The shifter hands out one
// symbol per cycle while the output register is free (out_ready or empty);
// a new pixel is accepted while earlier ones are still in flight.
// Reset: all stages empty, registers at their defaults (brightness 255,
// zero high 20, one high 40, period 60).
// Stall: when out_ready is low the output register holds its symbol and the
// stages behind it fill up and then drop in_ready; nothing is lost.
module ws2812_pixel_bit_encoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [wspbe_pkg::ColorW-1:0]    in_red,
  input  logic [wspbe_pkg::ColorW-1:0]    in_green,
  input  logic [wspbe_pkg::ColorW-1:0]    in_blue,
  input  logic                            in_last_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_data_bit,
  output logic [wspbe_pkg::TickW-1:0]     out_high_ticks,
  output logic [wspbe_pkg::TickW-1:0]     out_low_ticks,
  output logic                            out_pixel_end,
  output logic                            out_frame_end,
  input  logic                            cfg_we,
  input  logic [wspbe_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [wspbe_pkg::TickW-1:0]     cfg_wdata
);
  import wspbe_pkg::*;

  // Configuration registers
  logic [ColorW-1:0] brightness_r;
  logic [TickW-1:0]  zero_high_r;
  logic [TickW-1:0]  one_high_r;
  logic [TickW-1:0]  period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= BRIGHTNESS_RST;
      zero_high_r  <= ZERO_HIGH_RST;
      one_high_r   <= ONE_HIGH_RST;
      period_r     <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BRIGHTNESS: brightness_r <= cfg_wdata;
        REG_ZERO_HIGH:  zero_high_r  <= cfg_wdata;
        REG_ONE_HIGH:   one_high_r   <= cfg_wdata;
        REG_PERIOD:     period_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage valids and flow control
  logic s1_v_r, s2_v_r, ser_v_r, out_v_r;
  logic s1_ready, s2_ready, ser_load, emit, out_free, ser_done;
  logic [SymCntW-1:0] sym_cnt_r;

  assign out_free = !out_v_r || out_ready;
  assign emit     = ser_v_r && out_free;
  assign ser_done = emit && (sym_cnt_r == LAST_SYM);
  assign ser_load = !ser_v_r || ser_done;
  assign s2_ready = !s2_v_r || ser_load;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  // Stage 1: color times brightness
  logic [ProdW-1:0] prod_r_r, prod_g_r, prod_b_r;
  logic             s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      prod_r_r  <= ProdW'(in_red)   * ProdW'(brightness_r);
      prod_g_r  <= ProdW'(in_green) * ProdW'(brightness_r);
      prod_b_r  <= ProdW'(in_blue)  * ProdW'(brightness_r);
      s1_last_r <= in_last_pixel;
    end
  end

  // Stage 2: divide by 255 and pack in green, red, blue order
  logic [WordW-1:0] word_r;
  logic             s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v_r) begin
      word_r    <= {div255(prod_g_r), div255(prod_r_r), div255(prod_b_r)};
      s2_last_r <= s1_last_r;
    end
  end

  // Stage 3: symbol shifter, MSB first
  logic [WordW-1:0]   shift_r;
  logic               ser_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r   <= 1'b0;
      sym_cnt_r <= '0;
    end else if (ser_load) begin
      ser_v_r   <= s2_v_r;
      sym_cnt_r <= '0;
    end else if (emit) begin
      sym_cnt_r <= sym_cnt_r + SymCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      if (s2_v_r) begin
        shift_r    <= word_r;
        ser_last_r <= s2_last_r;
      end
    end else if (emit) begin
      shift_r <= {shift_r[WordW-2:0], 1'b0};
    end
  end

  // Symbol timing from the current bit
  logic             cur_bit;
  logic [TickW-1:0] high_nxt, low_nxt;

  always_comb begin
    cur_bit  = shift_r[WordW-1];
    high_nxt = cur_bit ? one_high_r : zero_high_r;
    low_nxt  = (period_r > high_nxt) ? (period_r - high_nxt) : '0;
  end

  // Output register
  logic             data_bit_r, pixel_end_r, frame_end_r;
  logic [TickW-1:0] high_r, low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= ser_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      data_bit_r  <= cur_bit;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
      pixel_end_r <= (sym_cnt_r == LAST_SYM);
      frame_end_r <= (sym_cnt_r == LAST_SYM) && ser_last_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_data_bit   = data_bit_r;
  assign out_high_ticks = high_r;
  assign out_low_ticks  = low_r;
  assign out_pixel_end  = pixel_end_r;
  assign out_frame_end  = frame_end_r;

endmodule
